// File: hw/rtl/imubsc_pkg.sv
// Shared types, constants and helpers for the IMU bias and scale calibrator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imubsc_pkg;
	localparam int SampleW     = 32;
	localparam int FracBits    = 16;
	localparam int MaxCalib    = 1024;
	localparam int CntW        = 11;
	localparam int GravW       = 31;
	localparam int SumW        = 42;
	localparam int MagW        = 42;
	localparam int SqW         = 86;
	localparam int RootW       = 43;
	localparam int ProdW       = 64;
	localparam int CfgW        = 31;
	localparam int IdxW        = 1;
	localparam logic [IdxW-1:0] RegCalibSamples = 1'b0;
	localparam logic [IdxW-1:0] RegGravityRef   = 1'b1;
	localparam logic [CntW-1:0] CalibSamplesRst = 11'd100;
	localparam logic [GravW-1:0] GravityRefRst  = 31'd642253;

	typedef struct packed {
		logic signed [SampleW-1:0] accel_x;
		logic signed [SampleW-1:0] accel_y;
		logic signed [SampleW-1:0] accel_z;
		logic signed [SampleW-1:0] gyro_x;
		logic signed [SampleW-1:0] gyro_y;
		logic signed [SampleW-1:0] gyro_z;
		logic                      calib_mode;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleW-1:0] rate_x;
		logic signed [SampleW-1:0] rate_y;
		logic signed [SampleW-1:0] rate_z;
		logic signed [SampleW-1:0] lin_acc_x;
		logic signed [SampleW-1:0] lin_acc_y;
		logic signed [SampleW-1:0] lin_acc_z;
		logic [31:0]               sequence_res;
	} out_item_t;

	// saturate sign plus magnitude to a signed sample
	function automatic logic [SampleW-1:0] sat_mag(input logic neg,
			input logic [ProdW-1:0] m);
		logic [SampleW-1:0] r;
		if (neg) begin
			if (m > ProdW'({1'b1, {(SampleW-1){1'b0}}}))
				r = {1'b1, {(SampleW-1){1'b0}}};
			else
				r = SampleW'(~m + 1'b1);
		end else begin
			if (m > ProdW'({1'b0, {(SampleW-1){1'b1}}}))
				r = {1'b0, {(SampleW-1){1'b1}}};
			else
				r = m[SampleW-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/imu_bias_scale_calibrator.sv
// IMU bias and scale calibrator top: handshake, accumulation, three lanes.
// Depends on imubsc_pkg, imubsc_lane, imubsc_solver.
// Timing: a calibrated item's result passes the lane registers, then the result register;
// one item is in flight at a time, so no new item is taken until the result is taken.
// Accumulating items are taken one per cycle. The item that ends a calibration run
// holds the input for the finish unit: six 42-step serial divisions, a sum of three
// squares, a 43-step square root and a 48-step gain division. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module imu_bias_scale_calibrator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire imubsc_pkg::in_item_t              in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output imubsc_pkg::out_item_t                  out_data,
	input  wire logic                              cfg_we,
	input  wire logic [imubsc_pkg::IdxW-1:0]       cfg_index,
	input  wire logic [imubsc_pkg::CfgW-1:0]       cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_LANE = 4'b0010, ST_SOLVE = 4'b0100, ST_OUT = 4'b1000
	} st_t;
	st_t st_q;
	logic [imubsc_pkg::CntW-1:0]  calib_samples_q, taken_q;
	logic [imubsc_pkg::GravW-1:0] gravity_q;
	logic calibrated_q, prev_mode_q, in_acc, out_acc;
	logic signed [imubsc_pkg::SumW-1:0] sum_q [6];
	logic signed [imubsc_pkg::SampleW-1:0] off_q [6];
	logic signed [imubsc_pkg::SampleW-1:0] mean [6];
	logic [31:0] gain_q, gain, msg_q;
	logic [imubsc_pkg::CntW-1:0] target, taken_nx;
	logic edge_rise, cal_now, finish;
	logic signed [imubsc_pkg::SampleW-1:0] samp [6];
	logic signed [imubsc_pkg::SampleW-1:0] hold_q [6];
	logic signed [imubsc_pkg::SampleW-1:0] rate [3], lacc [3];
	logic solv_busy, solv_done;
	imubsc_pkg::out_item_t res_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data = res_q;

	// effective run length and per-item decisions
	always_comb begin
		target = calib_samples_q;
		if (target == '0) target = imubsc_pkg::CntW'(1);
		if (target > imubsc_pkg::CntW'(imubsc_pkg::MaxCalib))
			target = imubsc_pkg::CntW'(imubsc_pkg::MaxCalib);
		edge_rise = in_data.calib_mode && !prev_mode_q;
		cal_now   = calibrated_q && !edge_rise;
		taken_nx  = (edge_rise ? '0 : taken_q) + imubsc_pkg::CntW'(1);
		finish    = !cal_now && (taken_nx >= target);
		samp[0] = in_data.accel_x; samp[1] = in_data.accel_y; samp[2] = in_data.accel_z;
		samp[3] = in_data.gyro_x;  samp[4] = in_data.gyro_y;  samp[5] = in_data.gyro_z;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_samples_q <= imubsc_pkg::CalibSamplesRst;
			gravity_q       <= imubsc_pkg::GravityRefRst;
		end else if (cfg_we) begin
			case (cfg_index)
				imubsc_pkg::RegCalibSamples:
					calib_samples_q <= cfg_data[imubsc_pkg::CntW-1:0];
				imubsc_pkg::RegGravityRef: gravity_q <= cfg_data[imubsc_pkg::GravW-1:0];
				default: ;
			endcase
		end
	end

	// control, accumulation and bias registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			calibrated_q <= 1'b0;
			prev_mode_q  <= 1'b0;
			taken_q <= '0;
			msg_q   <= '0;
			gain_q  <= '0;
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: if (in_acc) begin
					prev_mode_q <= in_data.calib_mode;
					if (cal_now) begin
						for (int i = 0; i < 6; i++) hold_q[i] <= samp[i];
						st_q <= ST_LANE;
					end else begin
						calibrated_q <= 1'b0;
						for (int i = 0; i < 6; i++)
							sum_q[i] <= (edge_rise ? '0 : sum_q[i])
								+ imubsc_pkg::SumW'(samp[i]);
						taken_q <= taken_nx;
						if (finish) st_q <= ST_SOLVE;
					end
				end
				ST_SOLVE: if (solv_done) begin
					// accel z bias stays zero
					for (int i = 0; i < 6; i++) begin
						sum_q[i] <= '0;
						off_q[i] <= (i == 2) ? '0 : mean[i];
					end
					gain_q <= gain;
					taken_q <= '0;
					calibrated_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_LANE: begin
					msg_q <= msg_q + 32'd1;
					st_q <= ST_OUT;
				end
				ST_OUT: if (out_acc) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result register, filled in the cycle after the lane products are registered
	always_ff @(posedge clk) begin
		if (st_q == ST_LANE) begin
			res_q.rate_x <= rate[0]; res_q.rate_y <= rate[1]; res_q.rate_z <= rate[2];
			res_q.lin_acc_x <= lacc[0]; res_q.lin_acc_y <= lacc[1];
			res_q.lin_acc_z <= lacc[2];
			res_q.sequence_res <= msg_q + 32'd1;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		imubsc_lane u_lane (
			.clk(clk), .en(st_q == ST_IDLE),
			.accel(in_acc ? samp[g] : hold_q[g]),
			.gyro(in_acc ? samp[g+3] : hold_q[g+3]),
			.accel_off(off_q[g]), .gyro_off(off_q[g+3]), .gain(gain_q),
			.rate(rate[g]), .lin_acc(lacc[g])
		);
	end

	imubsc_solver u_solver (
		.clk(clk), .arst_n(arst_n),
		.start(st_q == ST_SOLVE && !solv_busy && !solv_done),
		.count(taken_q), .sum(sum_q), .gravity(gravity_q),
		.busy(solv_busy), .done(solv_done), .mean(mean), .gain(gain)
	);

	ap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");
	ap_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> res_q.sequence_res == msg_q) else $error("sequence mismatch");
	ap_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> calibrated_q) else $error("result while uncalibrated");
endmodule
`default_nettype wire

// File: hw/rtl/imubsc_lane.sv
// One correction lane: gyro minus bias, (accel minus bias) times gain, saturated.
// Depends on imubsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imubsc_lane (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [imubsc_pkg::SampleW-1:0] accel,
	input  wire logic signed [imubsc_pkg::SampleW-1:0] gyro,
	input  wire logic signed [imubsc_pkg::SampleW-1:0] accel_off,
	input  wire logic signed [imubsc_pkg::SampleW-1:0] gyro_off,
	input  wire logic [31:0]                           gain,
	output logic signed [imubsc_pkg::SampleW-1:0]      rate,
	output logic signed [imubsc_pkg::SampleW-1:0]      lin_acc
);
	logic signed [imubsc_pkg::SampleW:0] gd, ad;
	logic [imubsc_pkg::SampleW:0]        amag;
	logic                                aneg_s1;
	logic [imubsc_pkg::SampleW-1:0]      rate_s1;
	logic [imubsc_pkg::ProdW:0]          prod_s1;
	logic [imubsc_pkg::ProdW-1:0]        gmag;

	// differences, one multiply, then saturation
	always_comb begin
		gd   = {gyro[imubsc_pkg::SampleW-1], gyro} - {gyro_off[imubsc_pkg::SampleW-1], gyro_off};
		ad   = {accel[imubsc_pkg::SampleW-1], accel} - {accel_off[imubsc_pkg::SampleW-1], accel_off};
		amag = ad[imubsc_pkg::SampleW] ? (imubsc_pkg::SampleW+1)'(-ad) : ad;
		gmag = gd[imubsc_pkg::SampleW] ? imubsc_pkg::ProdW'(-gd)
			: imubsc_pkg::ProdW'(gd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_s1 <= imubsc_pkg::sat_mag(gd[imubsc_pkg::SampleW], gmag);
			aneg_s1 <= ad[imubsc_pkg::SampleW];
			prod_s1 <= (imubsc_pkg::ProdW+1)'(amag * gain);
		end
	end

	always_comb begin
		rate = rate_s1;
		if (prod_s1[imubsc_pkg::ProdW:imubsc_pkg::FracBits+imubsc_pkg::ProdW-imubsc_pkg::FracBits] != '0)
			lin_acc = imubsc_pkg::sat_mag(aneg_s1, {imubsc_pkg::ProdW{1'b1}});
		else
			lin_acc = imubsc_pkg::sat_mag(aneg_s1,
				imubsc_pkg::ProdW'(prod_s1 >> imubsc_pkg::FracBits));
	end
endmodule
`default_nettype wire

// File: hw/rtl/imubsc_solver.sv
// Finish unit: means by serial division, length by bit-serial square root,
// gain by serial division. Depends on imubsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imubsc_solver (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic [imubsc_pkg::CntW-1:0]               count,
	input  wire logic signed [imubsc_pkg::SumW-1:0]        sum [6],
	input  wire logic [imubsc_pkg::GravW-1:0]              gravity,
	output logic                                           busy,
	output logic                                           done,
	output logic signed [imubsc_pkg::SampleW-1:0]          mean [6],
	output logic [31:0]                                    gain
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_MEAN = 5'b00010, ST_SQ = 5'b00100,
		ST_ROOT = 5'b01000, ST_GAIN = 5'b10000
	} st_t;
	st_t st_q;
	logic [6:0]                      step_q;
	logic [2:0]                      el_q;
	logic [imubsc_pkg::MagW-1:0]     quo_q;
	logic [imubsc_pkg::CntW:0]       rem_q;
	logic [imubsc_pkg::MagW-1:0]     num_q;
	logic signed [imubsc_pkg::SumW-1:0] mfull_q [3];
	logic [imubsc_pkg::SqW-1:0]      sq_q;
	logic [imubsc_pkg::RootW-1:0]    root_q;
	logic [imubsc_pkg::SqW+1:0]      rrem_q;
	logic [47:0]                     gnum_q;
	logic [48:0]                     grem_q;
	logic [47:0]                     gquo_q;
	logic [imubsc_pkg::MagW-1:0]     nmag;
	logic [imubsc_pkg::CntW:0]       rtry;
	logic [imubsc_pkg::SampleW-1:0]  mmag;
	logic [2*imubsc_pkg::SampleW-1:0] sqt;
	logic [imubsc_pkg::SqW+1:0]      rtrial, rshift;
	logic [48:0]                     gtry;
	logic signed [imubsc_pkg::SumW-1:0] qs;

	// helpers for one step of each serial unit
	always_comb begin
		nmag   = sum[el_q][imubsc_pkg::SumW-1] ? imubsc_pkg::MagW'(-sum[el_q])
			: imubsc_pkg::MagW'(sum[el_q]);
		rtry   = {rem_q[imubsc_pkg::CntW-1:0], num_q[imubsc_pkg::MagW-1]};
		qs     = sum[el_q][imubsc_pkg::SumW-1] ? -$signed(quo_q) : $signed(quo_q);
		// a mean fits a sample, so its magnitude fits SampleW unsigned bits
		mmag   = mfull_q[el_q[1:0]][imubsc_pkg::SumW-1]
			? imubsc_pkg::SampleW'(-mfull_q[el_q[1:0]])
			: imubsc_pkg::SampleW'(mfull_q[el_q[1:0]]);
		sqt    = mmag * mmag;
		rshift = {rrem_q[imubsc_pkg::SqW-1:0], sq_q[imubsc_pkg::SqW-1:imubsc_pkg::SqW-2]};
		rtrial = {root_q, 2'b01};
		gtry   = {grem_q[47:0], gnum_q[47]};
	end

	assign busy = (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done   <= 1'b0;
			step_q <= '0;
			el_q   <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: if (start) begin
					st_q   <= ST_MEAN;
					el_q   <= '0;
					step_q <= '0;
				end
				// restoring division of each sum by the count, one bit a cycle
				ST_MEAN: begin
					if (step_q == 7'd0) begin
						num_q  <= nmag;
						rem_q  <= '0;
						quo_q  <= '0;
						step_q <= 7'd1;
					end else if (step_q <= 7'(imubsc_pkg::MagW)) begin
						if (rtry >= {1'b0, count}) begin
							rem_q <= rtry - {1'b0, count};
							quo_q <= {quo_q[imubsc_pkg::MagW-2:0], 1'b1};
						end else begin
							rem_q <= rtry;
							quo_q <= {quo_q[imubsc_pkg::MagW-2:0], 1'b0};
						end
						num_q  <= num_q << 1;
						step_q <= step_q + 7'd1;
					end else begin
						mean[el_q] <= imubsc_pkg::SampleW'(qs);
						if (el_q < 3'd3) mfull_q[el_q[1:0]] <= qs;
						step_q <= '0;
						if (el_q == 3'd5) begin
							el_q <= '0;
							sq_q <= '0;
							st_q <= ST_SQ;
						end else begin
							el_q <= el_q + 3'd1;
						end
					end
				end
				// sum of squares, one 32-bit square per cycle
				ST_SQ: begin
					sq_q <= sq_q + imubsc_pkg::SqW'(sqt);
					if (el_q == 3'd2) begin
						st_q   <= ST_ROOT;
						root_q <= '0;
						rrem_q <= '0;
						step_q <= '0;
					end else begin
						el_q <= el_q + 3'd1;
					end
				end
				// bit-serial integer square root, two radicand bits a cycle
				ST_ROOT: begin
					sq_q <= sq_q << 2;
					if (rshift >= rtrial) begin
						rrem_q <= rshift - rtrial;
						root_q <= {root_q[imubsc_pkg::RootW-2:0], 1'b1};
					end else begin
						rrem_q <= rshift;
						root_q <= {root_q[imubsc_pkg::RootW-2:0], 1'b0};
					end
					if (step_q == 7'(imubsc_pkg::RootW - 1)) begin
						st_q   <= ST_GAIN;
						step_q <= '0;
						gnum_q <= {1'b0, gravity, 16'd0};
						grem_q <= '0;
						gquo_q <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				// gravity << frac divided by length, one bit a cycle
				ST_GAIN: begin
					if (step_q < 7'd48) begin
						if (49'(gtry) >= 49'(root_q)) begin
							grem_q <= gtry - 49'(root_q);
							gquo_q <= {gquo_q[46:0], 1'b1};
						end else begin
							grem_q <= gtry;
							gquo_q <= {gquo_q[46:0], 1'b0};
						end
						gnum_q <= gnum_q << 1;
						step_q <= step_q + 7'd1;
					end else begin
						if (root_q == '0 || gquo_q[47:32] != '0)
							gain <= 32'hFFFF_FFFF;
						else
							gain <= gquo_q[31:0];
						done <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> st_q == ST_IDLE) else $error("solver done not idle");
	ap_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && st_q == ST_IDLE) |=> busy) else $error("solver did not start");
	ap_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("solver state not one-hot");
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for imu_bias_scale_calibrator: directed table, then random calibration runs.
// Depends on imubsc_pkg and the block; results checked against table values or an in-bench predictor.
`timescale 1ns / 1ps
module tb_top;
	// stimulus table row: either a register write or an input item
	typedef struct {
		bit                             is_cfg;
		logic [imubsc_pkg::IdxW-1:0]    idx;
		logic [imubsc_pkg::CfgW-1:0]    val;
		imubsc_pkg::in_item_t           d;
		bit                             typed;
		imubsc_pkg::out_item_t          e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	imubsc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	imubsc_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [imubsc_pkg::IdxW-1:0] cfg_index = imubsc_pkg::RegCalibSamples;
	logic [imubsc_pkg::CfgW-1:0] cfg_data = '0;

	imu_bias_scale_calibrator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [imubsc_pkg::CntW-1:0]  n_target = imubsc_pkg::CalibSamplesRst;
	logic [imubsc_pkg::GravW-1:0] grav = imubsc_pkg::GravityRefRst;
	bit               calibrated = 0;
	bit               prev_md = 0;
	int               taken = 0;
	longint           acc_sum[3];
	longint           gyr_sum[3];
	longint           acc_bias[2];
	longint           gyr_bias[3];
	logic [31:0]      gain = '0;
	logic [31:0]      seq_cnt = '0;

	imubsc_pkg::out_item_t pending[$];
	bit               row_typed = 0;
	imubsc_pkg::out_item_t row_exp = '0;
	bit               calm = 0;
	bit               hold_req = 0;
	int               stall_left = 0;
	int               errors = 0;
	int               sent = 0;
	row_t             rows[$];

	function automatic logic [127:0] mag(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	// saturate sign plus magnitude to a signed 32-bit sample
	function automatic logic [31:0] sat32(bit neg, logic [127:0] m);
		if (neg)
			return (m > 128'h8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
		return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	// end of a calibration run: means, gravity length and accel gain
	task automatic close_run();
		longint n;
		longint m[3];
		logic [127:0] sq;
		logic [127:0] root;
		logic [127:0] t;
		logic [127:0] q;
		n = (taken < 1) ? 1 : taken;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = acc_sum[i] / n;
			gyr_bias[i] = gyr_sum[i] / n;
			sq += mag(m[i]) * mag(m[i]);
			acc_sum[i] = 0;
			gyr_sum[i] = 0;
		end
		acc_bias[0] = m[0];
		acc_bias[1] = m[1];
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			t = root | (128'd1 << b);
			if (t * t <= sq)
				root = t;
		end
		if (root == 0) begin
			gain = 32'hFFFF_FFFF;
		end else begin
			q = (128'(grav) << imubsc_pkg::FracBits) / root;
			gain = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		end
		calibrated = 1;
		taken = 0;
	endtask

	// one accepted sample: accumulate or produce a corrected item
	task automatic predict_sample(imubsc_pkg::in_item_t d, output bit has_res,
			output imubsc_pkg::out_item_t r);
		longint a[3];
		longint g[3];
		longint dv;
		int tgt;
		logic [127:0] p;
		a[0] = longint'($signed(d.accel_x));
		a[1] = longint'($signed(d.accel_y));
		a[2] = longint'($signed(d.accel_z));
		g[0] = longint'($signed(d.gyro_x));
		g[1] = longint'($signed(d.gyro_y));
		g[2] = longint'($signed(d.gyro_z));
		has_res = 0;
		r = '0;
		if (d.calib_mode && !prev_md) begin
			calibrated = 0;
			taken = 0;
			for (int i = 0; i < 3; i++) begin
				acc_sum[i] = 0;
				gyr_sum[i] = 0;
			end
		end
		prev_md = d.calib_mode;
		if (!calibrated) begin
			tgt = int'(n_target);
			if (tgt < 1) tgt = 1;
			if (tgt > imubsc_pkg::MaxCalib) tgt = imubsc_pkg::MaxCalib;
			for (int i = 0; i < 3; i++) begin
				acc_sum[i] += a[i];
				gyr_sum[i] += g[i];
			end
			taken++;
			if (taken >= tgt)
				close_run();
			return;
		end
		has_res = 1;
		r.rate_x = sat32(g[0] - gyr_bias[0] < 0, mag(g[0] - gyr_bias[0]));
		r.rate_y = sat32(g[1] - gyr_bias[1] < 0, mag(g[1] - gyr_bias[1]));
		r.rate_z = sat32(g[2] - gyr_bias[2] < 0, mag(g[2] - gyr_bias[2]));
		dv = a[0] - acc_bias[0];
		p = (mag(dv) * 128'(gain)) >> imubsc_pkg::FracBits;
		r.lin_acc_x = sat32(dv < 0, p);
		dv = a[1] - acc_bias[1];
		p = (mag(dv) * 128'(gain)) >> imubsc_pkg::FracBits;
		r.lin_acc_y = sat32(dv < 0, p);
		dv = a[2];
		p = (mag(dv) * 128'(gain)) >> imubsc_pkg::FracBits;
		r.lin_acc_z = sat32(dv < 0, p);
		seq_cnt++;
		r.sequence_res = seq_cnt;
	endtask

	task automatic cmp(string nm, logic [31:0] e, logic [31:0] a);
		if (a !== e) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, nm, e, a);
		end
	endtask

	// input side: predict; output side: check against oldest expectation
	always @(posedge clk) begin
		bit hr;
		imubsc_pkg::out_item_t r;
		imubsc_pkg::out_item_t e;
		if (arst_n && in_valid && !in_stall) begin
			predict_sample(in_data, hr, r);
			if (hr)
				pending.push_back(row_typed ? row_exp : r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got %h", $time, out_data);
			end else begin
				e = pending.pop_front();
				cmp("rate_x", e.rate_x, out_data.rate_x);
				cmp("rate_y", e.rate_y, out_data.rate_y);
				cmp("rate_z", e.rate_z, out_data.rate_z);
				cmp("lin_acc_x", e.lin_acc_x, out_data.lin_acc_x);
				cmp("lin_acc_y", e.lin_acc_y, out_data.lin_acc_y);
				cmp("lin_acc_z", e.lin_acc_z, out_data.lin_acc_z);
				cmp("sequence_res", e.sequence_res, out_data.sequence_res);
			end
			stall_left = calm ? 0 : $urandom_range(0, 5);
		end
	end

	// receiver: per-item stall, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				repeat (150) begin
					out_stall = 1'b1;
					@(negedge clk);
				end
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	function automatic imubsc_pkg::in_item_t mk_in(logic [31:0] ax, logic [31:0] ay,
			logic [31:0] az, logic [31:0] gx, logic [31:0] gy, logic [31:0] gz, logic md);
		imubsc_pkg::in_item_t d;
		d.accel_x = ax; d.accel_y = ay; d.accel_z = az;
		d.gyro_x = gx; d.gyro_y = gy; d.gyro_z = gz;
		d.calib_mode = md;
		return d;
	endfunction

	function automatic imubsc_pkg::out_item_t mk_out(logic [31:0] rx, logic [31:0] ry,
			logic [31:0] rz, logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
			logic [31:0] sq);
		imubsc_pkg::out_item_t o;
		o.rate_x = rx; o.rate_y = ry; o.rate_z = rz;
		o.lin_acc_x = lx; o.lin_acc_y = ly; o.lin_acc_z = lz;
		o.sequence_res = sq;
		return o;
	endfunction

	function automatic void add_cfg(logic [imubsc_pkg::IdxW-1:0] i,
			logic [imubsc_pkg::CfgW-1:0] v);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1; r.idx = i; r.val = v;
		rows.push_back(r);
	endfunction

	function automatic void add_item(imubsc_pkg::in_item_t d, bit typed,
			imubsc_pkg::out_item_t e);
		row_t r;
		r = '{default: '0};
		r.d = d; r.typed = typed; r.e = e;
		rows.push_back(r);
	endfunction

	// offer one item after a random gap, return at the falling edge after acceptance
	task automatic send(imubsc_pkg::in_item_t d, bit typed, imubsc_pkg::out_item_t e);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = d;
		row_typed = typed;
		row_exp = e;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	// register write once everything expected has come and the finish unit is done
	task automatic write_reg(logic [imubsc_pkg::IdxW-1:0] i, logic [imubsc_pkg::CfgW-1:0] v);
		in_valid = 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = i;
		cfg_data = v;
		if (i == imubsc_pkg::RegCalibSamples) n_target = v[imubsc_pkg::CntW-1:0];
		else grav = v[imubsc_pkg::GravW-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] pick(logic [31:0] base);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
			default: return base + 32'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	// random calibration runs
	task automatic random_phases();
		logic [31:0] bx, by, bz;
		logic [imubsc_pkg::CntW-1:0] ns;
		int n, cal_items;
		bit pressed;
		pressed = 0;
		while (sent < 900) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: ns = 0;
				1: ns = 1;
				2: ns = 11'd2;
				default: ns = 11'($urandom_range(1, 12));
			endcase
			write_reg(imubsc_pkg::RegCalibSamples, 31'(ns));
			case ($urandom_range(0, 3))
				0: write_reg(imubsc_pkg::RegGravityRef, 31'd1);
				1: write_reg(imubsc_pkg::RegGravityRef, 31'h7FFF_FFFF);
				2: write_reg(imubsc_pkg::RegGravityRef, imubsc_pkg::GravityRefRst);
				default: write_reg(imubsc_pkg::RegGravityRef,
					31'($urandom_range(1, 32'h7FFF_FFFF)));
			endcase
			case ($urandom_range(0, 5))
				0: begin bx = $urandom; by = $urandom; bz = $urandom; end
				1: begin bx = 0; by = 0; bz = 0; end
				default: begin
					bx = 32'($urandom_range(0, 20000));
					by = 32'($urandom_range(0, 20000));
					bz = ($urandom_range(0, 1)) ? 32'd642253 : -32'd642253;
				end
			endcase
			n = (ns == 0) ? 1 : ((ns > imubsc_pkg::MaxCalib) ? imubsc_pkg::MaxCalib : int'(ns));
			// leave calibration mode, then raise it to start a run
			send(mk_in(pick(bx), pick(by), pick(bz), $urandom, $urandom, $urandom, 1'b0),
				0, '0);
			for (int k = 0; k < n; k++) begin
				if (n > 4 && k == n / 2 && $urandom_range(0, 2) == 0)
					write_reg(imubsc_pkg::RegCalibSamples, 31'($urandom_range(1, k)));
				send(mk_in(bx + 32'($urandom_range(0, 255)), by + 32'($urandom_range(0, 255)),
					bz + 32'($urandom_range(0, 255)), 32'($urandom_range(0, 4095)),
					32'($urandom_range(0, 4095)), 32'($urandom_range(0, 4095)),
					(k == 0) ? 1'b1 : ($urandom_range(0, 19) != 0)), 0, '0);
				if (n > 100 && k % 100 == 99) n = (n > k + 1) ? n : k + 1;
			end
			if (!pressed && sent > 200) begin
				pressed = 1;
				hold_req = 1;
			end
			cal_items = $urandom_range(10, 30);
			repeat (cal_items)
				send(mk_in(pick(bx), pick(by), pick(bz), pick(32'h0), pick(32'h0), pick(32'h0),
					$urandom_range(0, 9) != 0), 0, '0);
		end
	endtask

	initial begin
		row_t r;
		add_cfg(imubsc_pkg::RegCalibSamples, 31'd1);
		// zero calibration sample: zero length gives full-scale gain
		add_item(mk_in(0, 0, 0, 0, 0, 0, 1'b0), 0, '0);
		add_item(mk_in(32'd1, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0), 1,
			mk_out(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0000_FFFF, 32'hFFFF_0001, 0, 1));
		add_item(mk_in(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 1'b0), 1,
			mk_out(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 2));
		// rising edge recalibrates on a z sample of 16.0 (Q16.16)
		add_item(mk_in(0, 0, 32'h0010_0000, 0, 0, 0, 1'b1), 0, '0);
		add_item(mk_in(0, 0, 32'h0010_0000, 0, 0, 0, 1'b1), 1,
			mk_out(0, 0, 0, 0, 0, 32'd642240, 3));
		add_cfg(imubsc_pkg::RegCalibSamples, 31'd3);
		add_item(mk_in(32'h0123_4567, 32'hFEDC_BA98, 32'h0009_CCCD, 32'h0000_1000,
			32'hFFFF_F000, 32'h7FFF_0000, 1'b1), 0, '0);
		add_item(mk_in(32'h0000_8000, 32'h0000_4000, 32'hFFF6_3333, 1, 2, 3, 1'b0), 0, '0);
		add_item(mk_in(32'h0000_1000, 32'h0000_2000, 32'h0009_C000, 5, 6, 7, 1'b1), 0, '0);
		add_item(mk_in(32'h0000_1100, 32'h0000_2100, 32'h0009_C100, 8, 9, 10, 1'b0), 0, '0);
		// rising edge while uncalibrated restarts the sums
		add_item(mk_in(32'h0000_0100, 32'hFFFF_FF00, 32'h0009_CCCD, 32'h40, 32'h50, 32'h60,
			1'b1), 0, '0);
		add_item(mk_in(32'h0000_0200, 32'hFFFF_FE00, 32'h0009_CDCD, 32'h41, 32'h51, 32'h61,
			1'b1), 0, '0);
		add_item(mk_in(32'h0000_0300, 32'hFFFF_FD00, 32'h0009_CECD, 32'h42, 32'h52, 32'h62,
			1'b1), 0, '0);
		add_item(mk_in(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0, '0);
		add_item(mk_in(32'h0000_0250, 32'hFFFF_FE50, 32'h0009_CD00, 32'h41, 32'h51, 32'h61,
			1'b1), 0, '0);
		add_cfg(imubsc_pkg::RegGravityRef, 31'h7FFF_FFFF);
		add_cfg(imubsc_pkg::RegCalibSamples, 31'd0);
		add_item(mk_in(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1, 1, 1, 1'b0), 0, '0);
		add_item(mk_in(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 1'b1), 0, '0);
		add_item(mk_in(32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 1'b1), 0, '0);
		add_item(mk_in(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 0, 0, 0, 1'b0), 0, '0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			r = rows[i];
			if (r.is_cfg)
				write_reg(r.idx, r.val);
			else
				send(r.d, r.typed, r.e);
		end
		row_typed = 0;
		random_phases();
		in_valid = 1'b0;
		calm = 1;
		while (pending.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		if (errors == 0)
			$display("[imu_bias_scale_calibrator] OK");
		else
			$display("[imu_bias_scale_calibrator] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("[imu_bias_scale_calibrator] ERROR");
		$finish;
	end
endmodule
